### sv/twis_pkg.sv
// Shared types and constants for the top-hat window intensity sum block.
package twis_pkg;

  localparam int unsigned MaxPeaks = 4096;
  localparam int unsigned CntW     = $clog2(MaxPeaks + 1);
  localparam int unsigned AddrW    = $clog2(MaxPeaks);

  localparam logic [1:0] ActStart = 2'd0;
  localparam logic [1:0] ActLoad  = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;

  localparam logic [1:0] CfgMzWindow = 2'd0;
  localparam logic [1:0] CfgPpmMode  = 2'd1;
  localparam logic [1:0] CfgImWindow = 2'd2;

  localparam logic [47:0] SumMax   = 48'hFFFF_FFFF_FFFF;
  localparam logic [27:0] PpmScale = 28'd200000000;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] spectrum_rt;
    logic [31:0] peak_mz;
    logic [31:0] peak_intensity;
    logic [19:0] peak_mobility;
    logic [31:0] target_mz;
    logic [19:0] target_mobility;
    logic        use_mobility;
    logic [31:0] rt_low;
    logic [31:0] rt_high;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_rt;
    logic [47:0] intensity_sum;
    logic        saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    PtrHold,
    PtrCur,
    PtrCurDec,
    PtrCurInc,
    PtrDec,
    PtrInc
  } ptr_sel_e;

  typedef struct packed {
    logic     start;
    logic     load;
    logic     qlatch;
    logic     cur_inc;
    logic     add;
    logic     out_load;
    ptr_sel_e ptr_sel;
  } cmd_t;

  typedef struct packed {
    logic q_skip;
    logic cur_lt_cnt;
    logic cur_nz;
    logic cur_inc_lt;
    logic ptr_nz;
    logic ptr_inc_lt;
    logic lt;
    logic mz_in;
    logic im_in;
    logic out_free;
  } st_t;

endpackage

### sv/twis_if.sv
// Valid/ready channel interfaces for input and result items.
interface twis_in_if;
  import twis_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface twis_out_if;
  import twis_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/twis_dp.sv
// Datapath: peak memory, cursor and pointer, window tests, accumulator, output register.
module twis_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [23:0]          cfg_data_i,
  input  twis_pkg::in_item_t   in_data_i,
  input  twis_pkg::cmd_t       cmd_i,
  output twis_pkg::st_t        st_o,
  output twis_pkg::out_item_t  out_data_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);
  import twis_pkg::*;

  logic [23:0] mzw_q;
  logic        ppm_q;
  logic [19:0] imw_q;

  logic [CntW-1:0] count_q, cursor_q, ptr_q, ptr_d;
  logic [31:0] rt_q;
  logic [31:0] tmz_q;
  logic [19:0] tim_q;
  logic        use_q;
  logic [55:0] tw_q;

  logic [83:0] mem [MaxPeaks];
  logic [83:0] rd_q;
  logic [31:0] rd_mz, rd_int;
  logic [19:0] rd_mob;

  logic [31:0] dmz_q, int_q;
  logic [19:0] dim_q;
  logic        lt_q;
  logic [59:0] pmz_q;

  logic [47:0] sum_q;
  logic        sat_q;
  logic [48:0] sum_ext;
  out_item_t   out_q;
  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mzw_q <= '0;
      ppm_q <= 1'b0;
      imw_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMzWindow: mzw_q <= cfg_data_i;
        CfgPpmMode:  ppm_q <= cfg_data_i[0];
        CfgImWindow: imw_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_sel)
      PtrCur:    ptr_d = cursor_q;
      PtrCurDec: ptr_d = cursor_q - 1'b1;
      PtrCurInc: ptr_d = cursor_q + 1'b1;
      PtrDec:    ptr_d = ptr_q - 1'b1;
      PtrInc:    ptr_d = ptr_q + 1'b1;
      default:   ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      ptr_q    <= '0;
      rt_q     <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.start) begin
        rt_q     <= in_data_i.spectrum_rt;
        count_q  <= '0;
        cursor_q <= '0;
      end else begin
        if (cmd_i.load && count_q < CntW'(MaxPeaks)) count_q <= count_q + 1'b1;
        if (cmd_i.cur_inc) cursor_q <= cursor_q + 1'b1;
      end
    end
  end

  // Peak memory: one write port for loads, one registered read at the pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CntW'(MaxPeaks)) begin
      mem[count_q[AddrW-1:0]] <= {in_data_i.peak_mz, in_data_i.peak_intensity,
                                  in_data_i.peak_mobility};
    end
    rd_q <= mem[ptr_q[AddrW-1:0]];
  end

  assign rd_mz  = rd_q[83:52];
  assign rd_int = rd_q[51:20];
  assign rd_mob = rd_q[19:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.qlatch) begin
      tmz_q <= in_data_i.target_mz;
      tim_q <= in_data_i.target_mobility;
      use_q <= in_data_i.use_mobility;
    end
    tw_q  <= tmz_q * mzw_q;
    dmz_q <= (rd_mz > tmz_q) ? rd_mz - tmz_q : tmz_q - rd_mz;
    dim_q <= (rd_mob > tim_q) ? rd_mob - tim_q : tim_q - rd_mob;
    lt_q  <= rd_mz < tmz_q;
    int_q <= rd_int;
    pmz_q <= dmz_q * PpmScale;
  end

  assign sum_ext = {1'b0, sum_q} + {17'b0, int_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.qlatch) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.add) begin
      if (sum_ext >= {1'b0, SumMax}) begin
        sum_q <= SumMax;
        if (sum_ext > {1'b0, SumMax}) sat_q <= 1'b1;
      end else begin
        sum_q <= sum_ext[47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= '{result_rt: rt_q, intensity_sum: sum_q, saturated: sat_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    st_o.q_skip = ((in_data_i.rt_high > in_data_i.rt_low) &&
                   (rt_q < in_data_i.rt_low || rt_q > in_data_i.rt_high)) ||
                  (count_q == '0);
    st_o.cur_lt_cnt = cursor_q < count_q;
    st_o.cur_nz     = cursor_q != '0;
    st_o.cur_inc_lt = ({1'b0, cursor_q} + 1'b1) < {1'b0, count_q};
    st_o.ptr_nz     = ptr_q != '0;
    st_o.ptr_inc_lt = ({1'b0, ptr_q} + 1'b1) < {1'b0, count_q};
    st_o.lt         = lt_q;
    st_o.mz_in      = ppm_q ? (pmz_q < {4'b0, tw_q}) : ({dmz_q, 1'b0} < {9'b0, mzw_q});
    st_o.im_in      = !(use_q && imw_q != '0) || ({dim_q, 1'b0} < {1'b0, imw_q});
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q) else $error("cursor past peak count");
  a_add_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |-> ptr_q < count_q) else $error("accumulate from unloaded entry");
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && sat_q |-> sum_q == SumMax) else $error("saturated sum not at max");

endmodule

### sv/twis_ctrl.sv
// Controller: sequences start, load and the query walk over the peak memory.
module twis_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_action_i,
  output logic            in_ready_o,
  input  twis_pkg::st_t   st_i,
  output twis_pkg::cmd_t  cmd_o
);
  import twis_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SQStart = 3'd1;
  localparam logic [2:0] SRd     = 3'd2;
  localparam logic [2:0] SE1     = 3'd3;
  localparam logic [2:0] SE2     = 3'd4;
  localparam logic [2:0] SE3     = 3'd5;
  localparam logic [2:0] SLStart = 3'd6;
  localparam logic [2:0] SRStart = 3'd7;

  localparam logic [1:0] PAdv   = 2'd0;
  localparam logic [1:0] PLeft  = 2'd1;
  localparam logic [1:0] PRight = 2'd2;
  localparam logic [1:0] PDone  = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;

  assign in_ready_o = (state_q == SIdle) && (phase_q != PDone);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '{ptr_sel: PtrHold, default: 1'b0};
    unique case (state_q)
      SIdle: begin
        if (phase_q == PDone) begin
          // finished query waits here for the output register
          if (st_i.out_free) begin
            cmd_o.out_load = 1'b1;
            phase_d = PAdv;
          end
        end else if (in_valid_i) begin
          unique case (in_action_i)
            ActStart: cmd_o.start = 1'b1;
            ActLoad:  cmd_o.load  = 1'b1;
            ActQuery: begin
              cmd_o.qlatch = 1'b1;
              if (!st_i.q_skip) state_d = SQStart;
            end
            default: ;
          endcase
        end
      end
      SQStart: begin
        if (st_i.cur_lt_cnt) begin
          cmd_o.ptr_sel = PtrCur;
          phase_d = PAdv;
          state_d = SRd;
        end else begin
          state_d = SLStart;
        end
      end
      SRd: state_d = SE1;
      SE1: state_d = SE2;
      SE2: state_d = SE3;
      SE3: begin
        unique case (phase_q)
          PAdv: begin
            if (st_i.lt) begin
              cmd_o.cur_inc = 1'b1;
              if (st_i.cur_inc_lt) begin
                cmd_o.ptr_sel = PtrCurInc;
                state_d = SRd;
              end else begin
                state_d = SLStart;
              end
            end else begin
              cmd_o.add = st_i.mz_in && st_i.im_in;
              state_d = SLStart;
            end
          end
          PLeft: begin
            if (st_i.mz_in) begin
              cmd_o.add = st_i.im_in;
              if (st_i.ptr_nz) begin
                cmd_o.ptr_sel = PtrDec;
                state_d = SRd;
              end else begin
                state_d = SRStart;
              end
            end else begin
              state_d = SRStart;
            end
          end
          default: begin
            if (st_i.mz_in) begin
              cmd_o.add = st_i.im_in;
              if (st_i.ptr_inc_lt) begin
                cmd_o.ptr_sel = PtrInc;
                state_d = SRd;
              end else begin
                phase_d = PDone;
                state_d = SIdle;
              end
            end else begin
              phase_d = PDone;
              state_d = SIdle;
            end
          end
        endcase
      end
      SLStart: begin
        if (st_i.cur_nz) begin
          cmd_o.ptr_sel = PtrCurDec;
          phase_d = PLeft;
          state_d = SRd;
        end else begin
          state_d = SRStart;
        end
      end
      default: begin
        if (st_i.cur_inc_lt) begin
          cmd_o.ptr_sel = PtrCurInc;
          phase_d = PRight;
          state_d = SRd;
        end else begin
          phase_d = PDone;
          state_d = SIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      phase_q <= PAdv;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

### sv/tophat_window_intensity_sum.sv
// Top level: windowed intensity sum over one stored spectrum of peaks.
// Start and load items are taken in SIdle without leaving it; a skipped query also stays in SIdle.
// A query visits each peak (cursor advance, center, left and right walk)
// through states SRd, SE1, SE2 and SE3, set by the registered memory read
// and the window-test multiplier stages, plus steps for accept, walk setup and output load.
// Reset (async, active low) clears peak count, cursor, spectrum time,
// registers and output valid; the peak memory holds no reset value.
module tophat_window_intensity_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  twis_in_if.sink     in_i,
  twis_out_if.source  out_o
);
  import twis_pkg::*;

  cmd_t cmd;
  st_t  st;

  // controller owns the handshake on the input side
  twis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.data.action),
    .in_ready_o  (in_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // datapath holds the store, the walk pointer and the output register
  twis_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_data_o  (out_o.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready)
  );

endmodule

### sim/tophat_window_intensity_sum_tb.sv
// Testbench for the top-hat window intensity sum block: directed table, then random spectra.
`timescale 1ns / 1ps

module tophat_window_intensity_sum_tb;
  import twis_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 24;   // margin for a skipped query or dropped load to settle

  // Expected-result source for one row of the directed table
  typedef enum logic [1:0] {
    ExpModel,  // predicted
    ExpNone,   // no result, typed in
    ExpTyped   // result typed in
  } exp_kind_e;

  typedef struct {
    in_item_t  item;
    exp_kind_e kind;
    out_item_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  twis_in_if  in_ch ();
  twis_out_if out_ch ();

  tophat_window_intensity_sum DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Predictor state: its own copy of the peak store and registers
  logic [31:0] pk_mz   [MaxPeaks];
  logic [31:0] pk_int  [MaxPeaks];
  logic [19:0] pk_mob  [MaxPeaks];
  int unsigned pk_cnt;
  int unsigned pk_cursor;
  logic [31:0] spec_rt;
  logic [23:0] win_mz;
  logic        win_ppm;
  logic [19:0] win_im;

  out_item_t   sums_pending[$];   // expected results, oldest first
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned src_idle;          // percent of cycles the sender idles
  int unsigned snk_idle;          // percent of cycles the receiver stalls
  int unsigned hold_left;         // long receiver hold-off, in cycles
  dir_row_t    dir_tbl[$];

  // Clock, 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle counter and timeout
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window tests, exact integer math
  // ---------------------------------------------------------------------------
  function automatic bit mz_hit(logic [31:0] peak, logic [31:0] tgt);
    longint unsigned d;
    d = (peak > tgt) ? longint'(peak - tgt) : longint'(tgt - peak);
    if (win_ppm)
      return d * 64'd200000000 < longint'(tgt) * longint'(win_mz);
    return 2 * d < longint'(win_mz);
  endfunction

  function automatic bit im_hit(logic [19:0] peak, logic [19:0] tgt, bit use_im);
    longint unsigned d;
    d = (peak > tgt) ? longint'(peak - tgt) : longint'(tgt - peak);
    if (!use_im) return 1'b1;
    return 2 * d < longint'(win_im);
  endfunction

  // Saturating 48-bit accumulate
  function automatic void sum_add(inout longint unsigned sum, inout bit sat,
                                  input logic [31:0] v);
    longint unsigned s;
    s = sum + longint'(v);
    if (s >= longint'(SumMax)) begin
      if (s > longint'(SumMax)) sat = 1'b1;
      s = longint'(SumMax);
    end
    sum = s;
  endfunction

  // Applies one accepted item to the predictor; returns 1 if it yields a result
  function automatic bit predict_sum(input in_item_t it, output out_item_t r);
    longint unsigned sum;
    bit          sat;
    bit          use_im;
    int unsigned i;
    sum = 0;
    sat = 1'b0;
    r   = '0;
    case (it.action)
      ActStart: begin
        spec_rt   = it.spectrum_rt;
        pk_cnt    = 0;
        pk_cursor = 0;
        return 1'b0;
      end
      ActLoad: begin
        // a full store drops the peak
        if (pk_cnt < MaxPeaks) begin
          pk_mz[pk_cnt]  = it.peak_mz;
          pk_int[pk_cnt] = it.peak_intensity;
          pk_mob[pk_cnt] = it.peak_mobility;
          pk_cnt++;
        end
        return 1'b0;
      end
      ActQuery: begin
        use_im = it.use_mobility && (win_im != 0);
        // retention time filter only applies to a range of positive width
        if (it.rt_high > it.rt_low && (spec_rt < it.rt_low || spec_rt > it.rt_high))
          return 1'b0;
        if (pk_cnt == 0) return 1'b0;
        if (pk_cursor > pk_cnt) pk_cursor = pk_cnt;
        while (pk_cursor < pk_cnt && pk_mz[pk_cursor] < it.target_mz) pk_cursor++;
        if (pk_cursor < pk_cnt &&
            mz_hit(pk_mz[pk_cursor], it.target_mz) &&
            im_hit(pk_mob[pk_cursor], it.target_mobility, use_im))
          sum_add(sum, sat, pk_int[pk_cursor]);
        i = pk_cursor;
        while (i > 0 && mz_hit(pk_mz[i-1], it.target_mz)) begin
          if (im_hit(pk_mob[i-1], it.target_mobility, use_im))
            sum_add(sum, sat, pk_int[i-1]);
          i--;
        end
        i = pk_cursor + 1;
        while (i < pk_cnt && mz_hit(pk_mz[i], it.target_mz)) begin
          if (im_hit(pk_mob[i], it.target_mobility, use_im))
            sum_add(sum, sat, pk_int[i]);
          i++;
        end
        r.result_rt     = spec_rt;
        r.intensity_sum = sum[47:0];
        r.saturated     = sat;
        return 1'b1;
      end
      default: return 1'b0;   // unknown action: ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders (unused fields random so every bit moves)
  // ---------------------------------------------------------------------------
  function automatic in_item_t rand_item();
    in_item_t it;
    it.action          = 2'($urandom);
    it.spectrum_rt     = $urandom;
    it.peak_mz         = $urandom;
    it.peak_intensity  = $urandom;
    it.peak_mobility   = 20'($urandom);
    it.target_mz       = $urandom;
    it.target_mobility = 20'($urandom);
    it.use_mobility    = 1'($urandom);
    it.rt_low          = $urandom;
    it.rt_high         = $urandom;
    return it;
  endfunction

  function automatic in_item_t mk_start(logic [31:0] rt);
    in_item_t it;
    it = rand_item();
    it.action      = ActStart;
    it.spectrum_rt = rt;
    return it;
  endfunction

  function automatic in_item_t mk_load(logic [31:0] mz, logic [31:0] inten,
                                       logic [19:0] mob);
    in_item_t it;
    it = rand_item();
    it.action         = ActLoad;
    it.peak_mz        = mz;
    it.peak_intensity = inten;
    it.peak_mobility  = mob;
    return it;
  endfunction

  function automatic in_item_t mk_query(logic [31:0] tmz, logic [19:0] tim, logic use_im,
                                        logic [31:0] lo, logic [31:0] hi);
    in_item_t it;
    it = rand_item();
    it.action          = ActQuery;
    it.target_mz       = tmz;
    it.target_mobility = tim;
    it.use_mobility    = use_im;
    it.rt_low          = lo;
    it.rt_high         = hi;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [31:0] rt, logic [47:0] sum, logic sat);
    out_item_t r;
    r.result_rt     = rt;
    r.intensity_sum = sum;
    r.saturated     = sat;
    return r;
  endfunction

  // Appends one row to the directed table
  task automatic add_row(input in_item_t it, input exp_kind_e kind, input out_item_t res);
    dir_row_t row;
    row.item = it;
    row.kind = kind;
    row.res  = res;
    dir_tbl.insert(dir_tbl.size(), row);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers one item, waits for the handshake, then predicts
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input exp_kind_e kind, input out_item_t typed);
    out_item_t r;
    bit        has;
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    has = predict_sum(it, r);
    if (kind == ExpTyped) sums_pending.insert(sums_pending.size(), typed);
    else if (kind == ExpModel && has) sums_pending.insert(sums_pending.size(), r);
  endtask

  task automatic send(input in_item_t it);
    send_item(it, ExpModel, '0);
  endtask

  // Waits until every expected result is out and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgMzWindow: win_mz  = val;
      CfgPpmMode:  win_ppm = val[0];
      CfgImWindow: win_im  = val[19:0];
      default: ;  // out-of-range index: no register
    endcase
  endtask

  task automatic set_windows(input logic [23:0] mzw, input logic ppm, input logic [19:0] imw);
    drain();
    cfg_write(CfgMzWindow, mzw);
    cfg_write(CfgPpmMode, {23'($urandom), ppm});  // upper bits must be dropped
    cfg_write(CfgImWindow, {4'($urandom), imw});
    cfg_write(2'd3, 24'($urandom));              // unmapped index, ignored
  endtask

  // ---------------------------------------------------------------------------
  // Random spectra: mostly sorted peaks and ascending queries, some noise
  // ---------------------------------------------------------------------------
  task automatic rand_spectrum(input int unsigned n_pk, input int unsigned n_q);
    logic [31:0] rt;
    logic [31:0] mz;
    logic [31:0] tgt;
    logic [31:0] last_tgt;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] step;
    logic [31:0] mz_list[$];
    logic [31:0] inten;
    longint unsigned nxt;
    rt       = $urandom;
    mz       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
    step     = $urandom_range(1, 1 << $urandom_range(0, 20));
    last_tgt = 0;
    send(mk_start(rt));
    for (int unsigned k = 0; k < n_pk; k++) begin
      inten = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
      if ($urandom_range(0, 14) == 0) begin
        send(mk_load($urandom, inten, 20'($urandom)));   // out-of-order peak
      end else begin
        send(mk_load(mz, inten, 20'($urandom)));
        mz_list.insert(mz_list.size(), mz);
        nxt = longint'(mz) + $urandom_range(0, step);
        mz  = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
      end
      if ($urandom_range(0, 29) == 0) begin
        in_item_t junk;
        junk = rand_item();
        junk.action = 2'd3;
        send(junk);
      end
    end
    for (int unsigned q = 0; q < n_q; q++) begin
      if (mz_list.size() != 0 && $urandom_range(0, 9) < 8) begin
        nxt = longint'(mz_list[$urandom_range(0, mz_list.size() - 1)])
              + $urandom_range(0, step) - (step / 2);
        tgt = nxt[31:0];
        if ($urandom_range(0, 4) != 0 && tgt < last_tgt) tgt = last_tgt;
      end else begin
        tgt = $urandom;
      end
      last_tgt = tgt;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          lo = $urandom;
          hi = $urandom;
        end
        4, 5: begin
          lo = (rt > 32'd100) ? rt - 32'd100 : 32'd0;
          hi = (rt < 32'hFFFF_FF00) ? rt + 32'd100 : 32'hFFFF_FFFF;
        end
        6: begin
          lo = rt;
          hi = rt;
        end
        7: begin
          lo = 32'd0;
          hi = 32'hFFFF_FFFF;
        end
        default: begin
          lo = 32'd0;
          hi = 32'd0;
        end
      endcase
      send(mk_query(tgt, 20'($urandom), 1'($urandom), lo, hi));
    end
  endtask

  task automatic rand_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_pk;
    int unsigned n_q;
    sent = 0;
    while (sent < n_items) begin
      n_pk = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      n_q  = $urandom_range(1, 8);
      rand_spectrum(n_pk, n_q);
      sent += n_pk + n_q + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
      @(posedge clk_i);
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (sums_pending.size() == 0) begin
        $display("%0t: unexpected result rt=%h sum=%h sat=%b", $realtime,
                 out_ch.data.result_rt, out_ch.data.intensity_sum, out_ch.data.saturated);
        err_cnt++;
      end else begin
        want = sums_pending.pop_front();
        if (out_ch.data.result_rt !== want.result_rt) begin
          $display("%0t: result_rt expected %h actual %h", $realtime,
                   want.result_rt, out_ch.data.result_rt);
          err_cnt++;
        end
        if (out_ch.data.intensity_sum !== want.intensity_sum) begin
          $display("%0t: intensity_sum expected %h actual %h", $realtime,
                   want.intensity_sum, out_ch.data.intensity_sum);
          err_cnt++;
        end
        if (out_ch.data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $realtime,
                   want.saturated, out_ch.data.saturated);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgMzWindow;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    err_cnt     = 0;
    hold_left   = 0;
    src_idle    = 8;
    snk_idle    = 59;
    pk_cnt      = 0;
    pk_cursor   = 0;
    spec_rt     = '0;
    win_mz      = '0;
    win_ppm     = 1'b0;
    win_im      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; window 256 LSB full width, absolute, no mobility
    add_row(mk_query(32'h1000, 20'h0, 1'b0, 32'd0, 32'd0), ExpNone, '0);   // empty store
    begin
      in_item_t junk;
      junk = rand_item();
      junk.action = 2'd3;
      add_row(junk, ExpNone, '0);                                          // unknown action
    end
    add_row(mk_start(32'd1000), ExpModel, '0);
    add_row(mk_load(32'h1000, 32'hFFFF_FFFF, 20'h0), ExpModel, '0);
    add_row(mk_load(32'h1010, 32'hFFFF_FFFF, 20'hF_FFFF), ExpModel, '0);
    add_row(mk_load(32'h1020, 32'd5, 20'h100), ExpModel, '0);
    // first and last peak each counted once
    add_row(mk_query(32'h1010, 20'h0, 1'b0, 32'd0, 32'd0), ExpTyped,
            mk_res(32'd1000, 48'h2_0000_0003, 1'b0));
    add_row(mk_query(32'h1010, 20'h0, 1'b1, 32'd2000, 32'd3000), ExpNone, '0); // rt excluded
    add_row(mk_query(32'h1018, 20'h0, 1'b0, 32'd500, 32'd1500), ExpModel, '0);
    add_row(mk_query(32'h1020, 20'h0, 1'b0, 32'd5000, 32'd10), ExpModel, '0);  // rt not a range
    add_row(mk_query(32'h0, 20'hF_FFFF, 1'b1, 32'd0, 32'd0), ExpModel, '0);     // descending
    add_row(mk_query(32'hFFFF_FFFF, 20'h0, 1'b0, 32'd0, 32'd0), ExpModel, '0);  // past the end
    add_row(mk_start(32'hFFFF_FFFF), ExpModel, '0);
    add_row(mk_load(32'h2000, 32'd7, 20'h0), ExpModel, '0);                    // unsorted
    add_row(mk_load(32'h5000, 32'd11, 20'h0), ExpModel, '0);
    add_row(mk_load(32'h2010, 32'd13, 20'h0), ExpModel, '0);
    add_row(mk_query(32'h2008, 20'h10, 1'b1, 32'd0, 32'hFFFF_FFFF), ExpModel, '0);
    add_row(mk_query(32'h2010, 20'h0, 1'b0, 32'd0, 32'd0), ExpModel, '0);
    add_row(mk_start(32'd0), ExpModel, '0);
    add_row(mk_load(32'hFFFF_FFFF, 32'd0, 20'hF_FFFF), ExpModel, '0);
    add_row(mk_query(32'hFFFF_FFFF, 20'h0, 1'b0, 32'd0, 32'd0), ExpTyped,
            mk_res(32'd0, 48'd0, 1'b0));

    set_windows(24'h100, 1'b0, 20'h0);
    foreach (dir_tbl[k]) send_item(dir_tbl[k].item, dir_tbl[k].kind, dir_tbl[k].res);

    // Random phases over several register settings, extremes included
    set_windows(24'h0, 1'b0, 20'h0);
    rand_phase(40);
    set_windows(24'h4000, 1'b0, 20'h800);
    rand_phase(90);
    src_idle = 59;
    snk_idle = 8;
    set_windows(24'hFF_FFFF, 1'b1, 20'hF_FFFF);
    rand_phase(80);
    set_windows(24'd200000, 1'b1, 20'h400);
    hold_left = 400;   // long stall: block fills and backs up its input
    rand_phase(90);
    src_idle = 0;
    snk_idle = 0;
    set_windows(24'hFF_FFFF, 1'b0, 20'h1);
    rand_phase(90);
    set_windows(24'h20_0000, 1'b0, 20'h2000);
    rand_phase(90);

    drain();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
